[src/owb_pkg.sv]
`timescale 1ns / 1ps
package owb_pkg;

  localparam int CFG_W = 10;

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_NONE     = 3'd0;
  localparam opcode_t OP_RESET    = 3'd1;
  localparam opcode_t OP_WR_BIT   = 3'd2;
  localparam opcode_t OP_WR_BYTE  = 3'd3;
  localparam opcode_t OP_RD_BIT   = 3'd4;
  localparam opcode_t OP_RD_BYTE  = 3'd5;
  localparam opcode_t OP_PULL_ON  = 3'd6;
  localparam opcode_t OP_PULL_OFF = 3'd7;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_RESET_LOW   = 3'd0;
  localparam reg_idx_t REG_PRES_WAIT   = 3'd1;
  localparam reg_idx_t REG_RESET_TAIL  = 3'd2;
  localparam reg_idx_t REG_SLOT_LOW    = 3'd3;
  localparam reg_idx_t REG_WRITE_HOLD  = 3'd4;
  localparam reg_idx_t REG_WRITE_REC   = 3'd5;
  localparam reg_idx_t REG_READ_SAMPLE = 3'd6;
  localparam reg_idx_t REG_READ_TAIL   = 3'd7;

  localparam logic [CFG_W-1:0] RST_RESET_LOW   = 10'd480;
  localparam logic [CFG_W-1:0] RST_PRES_WAIT   = 10'd70;
  localparam logic [CFG_W-1:0] RST_RESET_TAIL  = 10'd410;
  localparam logic [CFG_W-1:0] RST_SLOT_LOW    = 10'd6;
  localparam logic [CFG_W-1:0] RST_WRITE_HOLD  = 10'd54;
  localparam logic [CFG_W-1:0] RST_WRITE_REC   = 10'd5;
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE = 10'd9;
  localparam logic [CFG_W-1:0] RST_READ_TAIL   = 10'd55;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] presence_wait;
    logic [CFG_W-1:0] reset_tail;
    logic [CFG_W-1:0] slot_low;
    logic [CFG_W-1:0] write_hold;
    logic [CFG_W-1:0] write_recovery;
    logic [CFG_W-1:0] read_sample;
    logic [CFG_W-1:0] read_tail;
  } cfg_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_value;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence;
  } res_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_TAIL = 10'b00_0000_1000,
    PH_SLOT_LOW = 10'b00_0001_0000,
    PH_WR_HOLD  = 10'b00_0010_0000,
    PH_WR_REC   = 10'b00_0100_0000,
    PH_RD_WAIT  = 10'b00_1000_0000,
    PH_RD_TAIL  = 10'b01_0000_0000,
    PH_PULL     = 10'b10_0000_0000
  } phase_t;

endpackage

[src/owb_cfg.sv]
`timescale 1ns / 1ps
module owb_cfg
  import owb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  reg_idx_t         wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low      <= RST_RESET_LOW;
      cfg_r.presence_wait  <= RST_PRES_WAIT;
      cfg_r.reset_tail     <= RST_RESET_TAIL;
      cfg_r.slot_low       <= RST_SLOT_LOW;
      cfg_r.write_hold     <= RST_WRITE_HOLD;
      cfg_r.write_recovery <= RST_WRITE_REC;
      cfg_r.read_sample    <= RST_READ_SAMPLE;
      cfg_r.read_tail      <= RST_READ_TAIL;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESET_LOW:   cfg_r.reset_low      <= wr_data;
        REG_PRES_WAIT:   cfg_r.presence_wait  <= wr_data;
        REG_RESET_TAIL:  cfg_r.reset_tail     <= wr_data;
        REG_SLOT_LOW:    cfg_r.slot_low       <= wr_data;
        REG_WRITE_HOLD:  cfg_r.write_hold     <= wr_data;
        REG_WRITE_REC:   cfg_r.write_recovery <= wr_data;
        REG_READ_SAMPLE: cfg_r.read_sample    <= wr_data;
        REG_READ_TAIL:   cfg_r.read_tail      <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/owb_seq.sv]
`timescale 1ns / 1ps
module owb_seq
  import owb_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick_en,
  input  opcode_t    opcode,
  input  logic [7:0] tx_byte,
  input  logic       tx_bit,
  input  logic       pullup_after,
  input  logic       line_level,
  input  cfg_t       cfg,
  output res_t       res
);

  localparam int CMPW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  phase_t                 phase_r, phase_nxt, ph_s;
  opcode_t                cmd_r, cmd_nxt, cmd_s;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt, tick_s, tick_inc;
  logic [3:0]             bit_r, bit_nxt, bit_s, bit_inc;
  logic [7:0]             send_r, send_nxt, send_s;
  logic [7:0]             recv_r, recv_nxt, recv_s;
  logic                   pres_r, pres_nxt;
  logic                   spu_r, spu_nxt, spu_s;
  logic                   pend_r, pend_nxt, pend_s;
  logic [CFG_W-1:0]       dur;
  logic                   over, more_bits, do_slot_end, do_finish, done;
  logic                   de, dv;

  always_comb begin
    ph_s   = phase_r;
    cmd_s  = cmd_r;
    bit_s  = bit_r;
    tick_s = tick_r;
    send_s = send_r;
    recv_s = recv_r;
    spu_s  = spu_r;
    pend_s = pend_r;

    // start of a command, only from idle
    if (phase_r == PH_IDLE && opcode != OP_NONE) begin
      cmd_s  = opcode;
      bit_s  = '0;
      tick_s = '0;
      pend_s = 1'b0;
      case (opcode)
        OP_PULL_ON: begin
          spu_s = 1'b1;
          ph_s  = PH_PULL;
        end
        OP_PULL_OFF: begin
          spu_s = 1'b0;
          ph_s  = PH_PULL;
        end
        OP_RESET: begin
          spu_s = 1'b0;
          ph_s  = PH_RST_LOW;
        end
        OP_WR_BIT: begin
          spu_s  = 1'b0;
          ph_s   = PH_SLOT_LOW;
          send_s = {7'd0, tx_bit};
        end
        OP_WR_BYTE: begin
          spu_s  = 1'b0;
          ph_s   = PH_SLOT_LOW;
          send_s = tx_byte;
          pend_s = pullup_after;
        end
        default: begin
          spu_s  = 1'b0;
          ph_s   = PH_SLOT_LOW;
          recv_s = '0;
        end
      endcase
    end

    unique case (ph_s) inside
      PH_RST_LOW, PH_SLOT_LOW: begin
        de = 1'b1;
        dv = 1'b0;
      end
      PH_WR_HOLD: begin
        de = 1'b1;
        dv = send_s[0];
      end
      PH_IDLE, PH_PULL: begin
        de = spu_s;
        dv = spu_s;
      end
      default: begin
        de = 1'b0;
        dv = 1'b0;
      end
    endcase

    unique case (ph_s)
      PH_RST_LOW:  dur = cfg.reset_low;
      PH_RST_WAIT: dur = cfg.presence_wait;
      PH_RST_TAIL: dur = cfg.reset_tail;
      PH_SLOT_LOW: dur = cfg.slot_low;
      PH_WR_HOLD:  dur = cfg.write_hold;
      PH_WR_REC:   dur = cfg.write_recovery;
      PH_RD_WAIT:  dur = cfg.read_sample;
      PH_RD_TAIL:  dur = cfg.read_tail;
      default:     dur = CFG_W'(1);
    endcase

    // counter wrap acts as the clamp to 2**COUNT_WIDTH
    tick_inc  = tick_s + COUNT_WIDTH'(1);
    over      = (tick_inc == '0) || (CMPW'(tick_inc) >= CMPW'(dur));
    bit_inc   = bit_s + 4'd1;
    more_bits = (cmd_s == OP_WR_BYTE || cmd_s == OP_RD_BYTE) && (bit_inc < 4'd8);

    phase_nxt   = ph_s;
    cmd_nxt     = cmd_s;
    bit_nxt     = bit_s;
    tick_nxt    = tick_s;
    send_nxt    = send_s;
    recv_nxt    = recv_s;
    pres_nxt    = pres_r;
    spu_nxt     = spu_s;
    pend_nxt    = pend_s;
    do_slot_end = 1'b0;
    do_finish   = 1'b0;
    done        = 1'b0;

    if (ph_s != PH_IDLE) begin
      tick_nxt = tick_inc;
      if (over) begin
        tick_nxt = '0;
        unique case (ph_s)
          PH_RST_LOW: phase_nxt = PH_RST_WAIT;
          PH_RST_WAIT: begin
            pres_nxt  = ~line_level;
            phase_nxt = PH_RST_TAIL;
          end
          PH_SLOT_LOW: begin
            if (cmd_s == OP_WR_BIT || cmd_s == OP_WR_BYTE) begin
              phase_nxt = PH_WR_HOLD;
            end else begin
              phase_nxt = PH_RD_WAIT;
            end
          end
          PH_WR_HOLD: begin
            if (cfg.write_recovery == '0) begin
              do_slot_end = 1'b1;
            end else begin
              phase_nxt = PH_WR_REC;
            end
          end
          PH_RD_WAIT: begin
            if (cmd_s == OP_RD_BYTE) begin
              recv_nxt = {line_level, recv_s[7:1]};
            end else begin
              recv_nxt = {7'd0, line_level};
            end
            if (cfg.read_tail == '0) begin
              do_slot_end = 1'b1;
            end else begin
              phase_nxt = PH_RD_TAIL;
            end
          end
          PH_WR_REC, PH_RD_TAIL: do_slot_end = 1'b1;
          default: do_finish = 1'b1;
        endcase
      end
    end

    if (do_slot_end) begin
      bit_nxt = bit_inc;
      if (more_bits) begin
        send_nxt  = {1'b0, send_s[7:1]};
        phase_nxt = PH_SLOT_LOW;
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      done      = 1'b1;
      phase_nxt = PH_IDLE;
      tick_nxt  = '0;
      if (cmd_s == OP_WR_BYTE) begin
        spu_nxt = pend_s;
      end
      pend_nxt = 1'b0;
    end

    res.drive_enable = de;
    res.drive_value  = dv;
    res.busy_res     = (ph_s != PH_IDLE);
    res.done_res     = done;
    res.read_data    = recv_nxt;
    res.presence     = pres_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= OP_NONE;
      tick_r  <= '0;
      bit_r   <= '0;
      send_r  <= '0;
      recv_r  <= '0;
      pres_r  <= 1'b0;
      spu_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else if (tick_en) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      send_r  <= send_nxt;
      recv_r  <= recv_nxt;
      pres_r  <= pres_nxt;
      spu_r   <= spu_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

[src/owb_out.sv]
`timescale 1ns / 1ps
module owb_out
  import owb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t out_d_r, skid_d_r;
  logic out_load, skid_load;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_load   = 1'b0;
    skid_load  = 1'b0;
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_load  = push;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_load  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_d_r <= push_res;
    end else if (skid_v_r && (!out_v_r || !out_stall)) begin
      out_d_r <= skid_d_r;
    end
    if (skid_load) begin
      skid_d_r <= push_res;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_res   = out_d_r;

endmodule

[src/one_wire_bus_master.sv]
`timescale 1ns / 1ps
// a tick's result is formed combinationally and registered in the output
// stage (via its skid entry on out_stall); throughput: one tick per cycle
// while in_stall is low; a two-entry output stage takes ticks while a result
// waits, and in_stall rises only when both entries are full
// reset: synchronous active-low rst_n; sequencer idle, bus released,
// timing registers back to their default durations
module one_wire_bus_master
  import owb_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_opcode,
  input  logic [7:0]       in_tx_byte,
  input  logic             in_tx_bit,
  input  logic             in_pullup_after,
  input  logic             in_line_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_drive_enable,
  output logic             out_drive_value,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_read_data,
  output logic             out_presence,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t seq_res, out_res;
  logic tick_en, full;

  assign cfg_ready = 1'b1;
  assign tick_en   = in_valid && !full;
  assign in_stall  = full;

  owb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owb_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_en      (tick_en),
    .opcode       (in_opcode),
    .tx_byte      (in_tx_byte),
    .tx_bit       (in_tx_bit),
    .pullup_after (in_pullup_after),
    .line_level   (in_line_level),
    .cfg          (cfg),
    .res          (seq_res)
  );

  owb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick_en),
    .push_res  (seq_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_drive_enable = out_res.drive_enable;
  assign out_drive_value  = out_res.drive_value;
  assign out_busy_res     = out_res.busy_res;
  assign out_done_res     = out_res.done_res;
  assign out_read_data    = out_res.read_data;
  assign out_presence     = out_res.presence;

endmodule
